[hw/rtl/rpn_pkg.sv]
// Shared types and constants for the RPN stack calculator.
package rpn_pkg;

    localparam int ValW    = 32;
    localparam int VarIdxW = 5;
    localparam int DvdW    = 48;
    localparam int DvsW    = 32;

    typedef enum logic [3:0] {
        ACT_NUM     = 4'd0,
        ACT_VAR     = 4'd1,
        ACT_ADD     = 4'd2,
        ACT_MUL     = 4'd3,
        ACT_SUB     = 4'd4,
        ACT_DIV     = 4'd5,
        ACT_MOD     = 4'd6,
        ACT_PRINT   = 4'd7,
        ACT_RECALL  = 4'd8,
        ACT_DUP     = 4'd9,
        ACT_SWAP    = 4'd10,
        ACT_CLEAR   = 4'd11,
        ACT_NEWLINE = 4'd12,
        ACT_UNKNOWN = 4'd13
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_ZERO_DIV = 3'd3,
        ST_UNKNOWN  = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_POP,
        OP_CAP_A,
        OP_CAP_B,
        OP_PUSH_NUM,
        OP_PUSH_VAR,
        OP_PUSH_RECENT,
        OP_PUSH_A,
        OP_PUSH_B,
        OP_PUSH_RES,
        OP_DUP_PUSH,
        OP_ADD,
        OP_SUB,
        OP_MUL_P,
        OP_MUL_S,
        OP_DIV_START,
        OP_DIV_END,
        OP_MOD_START,
        OP_MOD_END,
        OP_VAR_STORE,
        OP_PRINT,
        OP_CLEAR,
        OP_SKIP_CLR,
        OP_NL_SHOW,
        OP_FLAG_UNK,
        OP_FLAG_ZDIV
    } t_dp_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CAPB,
        S_POPA,
        S_CAPA,
        S_EXEC,
        S_MULS,
        S_WAIT,
        S_PUSH1,
        S_PUSH2,
        S_DONE
    } t_state;

    typedef struct packed {
        t_dp_op op;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_action action;
        logic    vi_ok;
        logic    var_full;
        logic    skip;
        logic    div_zero;
        logic    mod_zero;
        logic    div_busy;
        logic    out_full;
    } t_dp_stat;

endpackage

[hw/rtl/rpn_div.sv]
// Iterative restoring divider on magnitudes, one quotient bit per cycle.
module rpn_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [rpn_pkg::DvdW-1:0] i_dividend,
    input  logic [rpn_pkg::DvsW-1:0] i_divisor,
    output logic                    o_busy,
    output logic [rpn_pkg::DvdW-1:0] o_quotient,
    output logic [rpn_pkg::DvsW-1:0] o_remainder
);
    import rpn_pkg::*;

    localparam int CntW = $clog2(DvdW + 1);

    logic            r_busy, n_busy;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [DvdW-1:0] r_quo, n_quo;
    logic [DvsW-1:0] r_rem, n_rem;
    logic [DvsW-1:0] r_dvs, n_dvs;
    logic [DvsW:0]   shifted;
    logic [DvsW:0]   diff;
    logic            ge;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        shifted = {r_rem, r_quo[DvdW-1]};
        diff    = shifted - {1'b0, r_dvs};
        ge      = shifted >= {1'b0, r_dvs};
    end

    // Load on start, then shift one bit a cycle
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CntW'(DvdW);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[DvdW-2:0], ge};
            n_rem = ge ? diff[DvsW-1:0] : shifted[DvsW-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[hw/rtl/rpn_dp.sv]
// Datapath: operand stack memory, variables, arithmetic and result register.
module rpn_dp #(
    parameter int STACK_DEPTH    = 128,
    parameter int VARIABLE_COUNT = 26
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rpn_pkg::t_dp_cmd           i_cmd,
    output rpn_pkg::t_dp_stat          o_stat,
    input  logic [3:0]                 i_action,
    input  logic [rpn_pkg::ValW-1:0]   i_number_value,
    input  logic [rpn_pkg::VarIdxW-1:0] i_variable_index,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [rpn_pkg::ValW-1:0]   o_shown_value,
    output logic                       o_value_shown,
    output logic [2:0]                 o_status
);
    import rpn_pkg::*;

    localparam int AddrW = $clog2(STACK_DEPTH);
    localparam int SpW   = $clog2(STACK_DEPTH + 1);
    localparam int VIdxW = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;

    localparam logic signed [63:0] MaxV = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] MinV = -64'sh0000_0000_8000_0000;

    // Stack memory
    logic [ValW-1:0] r_mem [STACK_DEPTH];
    logic [ValW-1:0] r_rd_data;
    logic [AddrW-1:0] rd_addr;
    logic             mem_we;
    logic [ValW-1:0]  mem_wdata;

    // Variables
    logic [ValW-1:0]           r_var [VARIABLE_COUNT];
    logic [VARIABLE_COUNT-1:0] r_var_full, n_var_full;
    logic                      var_we;
    logic [VIdxW-1:0]          vidx;

    // Working registers
    t_action            r_action, n_action;
    logic [ValW-1:0]    r_num, n_num;
    logic [VarIdxW-1:0] r_vi, n_vi;
    logic [SpW-1:0]     r_sp, n_sp;
    logic               r_pop_empty, n_pop_empty;
    logic signed [ValW-1:0] r_a, n_a, r_b, n_b, r_res, n_res;
    logic signed [63:0] r_prod, n_prod;
    logic [ValW-1:0]    r_recent, n_recent;
    logic               r_skip, n_skip;
    t_status            r_status, n_status;
    logic [ValW-1:0]    r_show, n_show;
    logic               r_shown, n_shown;
    logic               r_neg, n_neg;

    // Result register
    logic               r_out_valid;
    logic [ValW-1:0]    r_out_value;
    logic               r_out_shown;
    t_status            r_out_status;

    // Divider hookup
    logic               div_start;
    logic [DvdW-1:0]    div_dvd;
    logic [DvsW-1:0]    div_dvs;
    logic               div_busy;
    logic [DvdW-1:0]    div_quo;
    logic [DvsW-1:0]    div_rem;

    logic [ValW-1:0]    a_mag, b_mag;
    logic               vi_ok;
    logic               push_req;
    logic [ValW-1:0]    push_val;
    t_status            flag_code;
    logic signed [ValW:0]  sum;
    logic signed [63:0]    shifted_prod;
    logic [ValW-1:0]       mod_val;

    rpn_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dvd),
        .i_divisor   (div_dvs),
        .o_busy      (div_busy),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Operand magnitudes and variable index check
    always_comb begin
        a_mag = r_a[ValW-1] ? ValW'(-r_a) : ValW'(r_a);
        b_mag = r_b[ValW-1] ? ValW'(-r_b) : ValW'(r_b);
        vi_ok = r_vi < VarIdxW'(VARIABLE_COUNT);
        vidx  = r_vi[VIdxW-1:0];
    end

    // Divider operands for divide and modulo
    always_comb begin
        div_start = (i_cmd.op == OP_DIV_START) || (i_cmd.op == OP_MOD_START);
        if (i_cmd.op == OP_MOD_START) begin
            div_dvd = {32'd0, a_mag[ValW-1:16]};
            div_dvs = {16'd0, b_mag[ValW-1:16]};
        end else begin
            div_dvd = {a_mag, 16'd0};
            div_dvs = b_mag;
        end
    end

    always_comb begin
        sum          = '0;
        shifted_prod = r_prod >>> 16;
        mod_val      = {div_rem[15:0], 16'd0};
        n_action     = r_action;
        n_num        = r_num;
        n_vi         = r_vi;
        n_sp         = r_sp;
        n_pop_empty  = r_pop_empty;
        n_a          = r_a;
        n_b          = r_b;
        n_res        = r_res;
        n_prod       = r_prod;
        n_recent     = r_recent;
        n_skip       = r_skip;
        n_show       = r_show;
        n_shown      = r_shown;
        n_neg        = r_neg;
        n_var_full   = r_var_full;
        var_we       = 1'b0;
        push_req     = 1'b0;
        push_val     = '0;
        flag_code    = ST_OK;
        mem_we       = 1'b0;
        mem_wdata    = '0;
        rd_addr      = AddrW'(r_sp - 1'b1);

        case (i_cmd.op)
            OP_LOAD: begin
                n_action = t_action'(i_action);
                n_num    = i_number_value;
                n_vi     = i_variable_index;
                n_show   = '0;
                n_shown  = 1'b0;
            end
            OP_POP: begin
                if (r_sp != '0) begin
                    n_sp        = r_sp - 1'b1;
                    n_pop_empty = 1'b0;
                end else begin
                    n_pop_empty = 1'b1;
                    flag_code   = ST_EMPTY;
                end
            end
            OP_CAP_A: n_a = r_pop_empty ? '0 : r_rd_data;
            OP_CAP_B: n_b = r_pop_empty ? '0 : r_rd_data;
            OP_PUSH_NUM: begin
                push_req = 1'b1;
                push_val = r_num;
            end
            OP_PUSH_VAR: begin
                push_req         = 1'b1;
                push_val         = r_var[vidx];
                n_var_full[vidx] = 1'b0;
            end
            OP_PUSH_RECENT: begin
                push_req = 1'b1;
                push_val = r_recent;
            end
            OP_PUSH_A: begin
                push_req = 1'b1;
                push_val = r_a;
            end
            OP_PUSH_B: begin
                push_req = 1'b1;
                push_val = r_b;
            end
            OP_PUSH_RES: begin
                push_req = 1'b1;
                push_val = r_res;
            end
            OP_DUP_PUSH: begin
                push_req = 1'b1;
                push_val = r_a;
                n_skip   = 1'b0;
            end
            OP_ADD, OP_SUB: begin
                if (i_cmd.op == OP_ADD) begin
                    sum = {r_a[ValW-1], r_a} + {r_b[ValW-1], r_b};
                end else begin
                    sum = {r_a[ValW-1], r_a} - {r_b[ValW-1], r_b};
                end
                if (sum[ValW] != sum[ValW-1]) begin
                    flag_code = ST_OVERFLOW;
                    n_res     = sum[ValW] ? MinV[ValW-1:0] : MaxV[ValW-1:0];
                end else begin
                    n_res = sum[ValW-1:0];
                end
            end
            OP_MUL_P: n_prod = r_a * r_b;
            OP_MUL_S: begin
                if (shifted_prod > MaxV) begin
                    flag_code = ST_OVERFLOW;
                    n_res     = MaxV[ValW-1:0];
                end else if (shifted_prod < MinV) begin
                    flag_code = ST_OVERFLOW;
                    n_res     = MinV[ValW-1:0];
                end else begin
                    n_res = shifted_prod[ValW-1:0];
                end
            end
            OP_DIV_START: n_neg = r_a[ValW-1] ^ r_b[ValW-1];
            OP_MOD_START: n_neg = r_a[ValW-1];
            OP_DIV_END: begin
                if (!r_neg && (div_quo > DvdW'(MaxV))) begin
                    flag_code = ST_OVERFLOW;
                    n_res     = MaxV[ValW-1:0];
                end else if (r_neg && (div_quo > DvdW'(-MinV))) begin
                    flag_code = ST_OVERFLOW;
                    n_res     = MinV[ValW-1:0];
                end else begin
                    n_res = r_neg ? -div_quo[ValW-1:0] : div_quo[ValW-1:0];
                end
            end
            OP_MOD_END: n_res = r_neg ? -mod_val : mod_val;
            OP_VAR_STORE: begin
                n_recent         = r_b;
                var_we           = 1'b1;
                n_var_full[vidx] = 1'b1;
                n_show           = r_b;
                n_shown          = 1'b1;
                n_skip           = 1'b1;
            end
            OP_PRINT: begin
                n_show  = r_recent;
                n_shown = 1'b1;
                n_skip  = 1'b1;
            end
            OP_CLEAR: begin
                n_sp   = '0;
                n_skip = 1'b1;
            end
            OP_SKIP_CLR: n_skip = 1'b0;
            OP_NL_SHOW: begin
                n_recent = r_b;
                n_show   = r_b;
                n_shown  = 1'b1;
            end
            OP_FLAG_UNK:  flag_code = ST_UNKNOWN;
            OP_FLAG_ZDIV: flag_code = ST_ZERO_DIV;
            default: ;
        endcase

        // Push into the stack or flag a full stack
        if (push_req) begin
            if (r_sp < SpW'(STACK_DEPTH)) begin
                mem_we    = 1'b1;
                mem_wdata = push_val;
                n_sp      = r_sp + 1'b1;
            end else begin
                flag_code = ST_FULL;
            end
        end

        // Keep only the first error of the command
        if (i_cmd.op == OP_LOAD) begin
            n_status = ST_OK;
        end else if (r_status == ST_OK) begin
            n_status = flag_code;
        end else begin
            n_status = r_status;
        end
    end

    // Stack memory write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_sp[AddrW-1:0]] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Variable store
    always_ff @(posedge i_clk) begin
        if (var_we) begin
            r_var[vidx] <= r_b;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp         <= '0;
            r_var_full   <= '0;
            r_recent     <= '0;
            r_skip       <= 1'b0;
            r_status     <= ST_OK;
            r_out_valid  <= 1'b0;
        end else begin
            r_sp       <= n_sp;
            r_var_full <= n_var_full;
            r_recent   <= n_recent;
            r_skip     <= n_skip;
            r_status   <= n_status;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_num       <= n_num;
        r_vi        <= n_vi;
        r_pop_empty <= n_pop_empty;
        r_a         <= n_a;
        r_b         <= n_b;
        r_res       <= n_res;
        r_prod      <= n_prod;
        r_show      <= n_show;
        r_shown     <= n_shown;
        r_neg       <= n_neg;
        if (i_cmd.out_load) begin
            r_out_value  <= r_show;
            r_out_shown  <= r_shown;
            r_out_status <= r_status;
        end
    end

    always_comb begin
        o_stat.action   = r_action;
        o_stat.vi_ok    = vi_ok;
        o_stat.var_full = r_var_full[vidx];
        o_stat.skip     = r_skip;
        o_stat.div_zero = (r_b == '0);
        o_stat.mod_zero = (b_mag[ValW-1:16] == '0);
        o_stat.div_busy = div_busy;
        o_stat.out_full = r_out_valid;
    end

    assign o_out_valid   = r_out_valid;
    assign o_shown_value = r_out_value;
    assign o_value_shown = r_out_shown;
    assign o_status      = r_out_status;

endmodule

[hw/rtl/rpn_ctrl.sv]
// Controller: sequences pops, arithmetic and pushes for one command.
module rpn_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rpn_pkg::t_dp_stat  i_stat,
    output rpn_pkg::t_dp_cmd   o_cmd
);
    import rpn_pkg::*;

    t_state r_state, n_state;
    logic   zdiv;

    assign zdiv = ((i_stat.action == ACT_DIV) && i_stat.div_zero) ||
                  ((i_stat.action == ACT_MOD) && i_stat.mod_zero);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.action)
                    ACT_VAR: begin
                        if (i_stat.vi_ok && !i_stat.var_full) begin
                            n_state = S_CAPB;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD, ACT_SWAP:
                        n_state = S_CAPB;
                    ACT_NEWLINE: n_state = i_stat.skip ? S_DONE : S_CAPB;
                    ACT_DUP:     n_state = S_CAPA;
                    default:     n_state = S_DONE;
                endcase
            end
            S_CAPB: begin
                if ((i_stat.action == ACT_VAR) || (i_stat.action == ACT_NEWLINE)) begin
                    n_state = S_EXEC;
                end else begin
                    n_state = S_POPA;
                end
            end
            S_POPA:  n_state = zdiv ? S_DONE : S_CAPA;
            S_CAPA:  n_state = S_EXEC;
            S_EXEC: begin
                case (i_stat.action)
                    ACT_ADD, ACT_SUB:   n_state = S_PUSH1;
                    ACT_MUL:            n_state = S_MULS;
                    ACT_DIV, ACT_MOD:   n_state = S_WAIT;
                    ACT_DUP, ACT_SWAP:  n_state = S_PUSH2;
                    default:            n_state = S_DONE;
                endcase
            end
            S_MULS:  n_state = S_PUSH1;
            S_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_PUSH1;
                end
            end
            S_PUSH1: n_state = S_DONE;
            S_PUSH2: n_state = S_DONE;
            S_DONE: begin
                if (!i_stat.out_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd.op       = OP_NOP;
        o_cmd.out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                end
            end
            S_DECODE: begin
                case (i_stat.action)
                    ACT_NUM: o_cmd.op = OP_PUSH_NUM;
                    ACT_VAR: begin
                        if (!i_stat.vi_ok) begin
                            o_cmd.op = OP_FLAG_UNK;
                        end else if (i_stat.var_full) begin
                            o_cmd.op = OP_PUSH_VAR;
                        end else begin
                            o_cmd.op = OP_POP;
                        end
                    end
                    ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD, ACT_SWAP, ACT_DUP:
                        o_cmd.op = OP_POP;
                    ACT_NEWLINE: o_cmd.op = i_stat.skip ? OP_SKIP_CLR : OP_POP;
                    ACT_PRINT:   o_cmd.op = OP_PRINT;
                    ACT_RECALL:  o_cmd.op = OP_PUSH_RECENT;
                    ACT_CLEAR:   o_cmd.op = OP_CLEAR;
                    default:     o_cmd.op = OP_FLAG_UNK;
                endcase
            end
            S_CAPB: o_cmd.op = OP_CAP_B;
            S_POPA: o_cmd.op = zdiv ? OP_FLAG_ZDIV : OP_POP;
            S_CAPA: o_cmd.op = OP_CAP_A;
            S_EXEC: begin
                case (i_stat.action)
                    ACT_VAR:     o_cmd.op = OP_VAR_STORE;
                    ACT_NEWLINE: o_cmd.op = OP_NL_SHOW;
                    ACT_ADD:     o_cmd.op = OP_ADD;
                    ACT_SUB:     o_cmd.op = OP_SUB;
                    ACT_MUL:     o_cmd.op = OP_MUL_P;
                    ACT_DIV:     o_cmd.op = OP_DIV_START;
                    ACT_MOD:     o_cmd.op = OP_MOD_START;
                    ACT_DUP:     o_cmd.op = OP_DUP_PUSH;
                    ACT_SWAP:    o_cmd.op = OP_PUSH_B;
                    default:     o_cmd.op = OP_NOP;
                endcase
            end
            S_MULS: o_cmd.op = OP_MUL_S;
            S_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = (i_stat.action == ACT_MOD) ? OP_MOD_END : OP_DIV_END;
                end
            end
            S_PUSH1: o_cmd.op = OP_PUSH_RES;
            S_PUSH2: o_cmd.op = (i_stat.action == ACT_DUP) ? OP_DUP_PUSH : OP_PUSH_A;
            S_DONE:  o_cmd.out_load = !i_stat.out_full;
            default: o_cmd.op = OP_NOP;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hw/rtl/rpn_stack_calculator_top.sv]
// Top level of the RPN stack calculator: controller plus datapath.
//
// Channel   Dir  Group     Content
// command   in   s_axis    tuser = action, tdata = number_value, variable_index
// result    out  m_axis    tuser = value_shown, tdata = shown_value, status
//
// Divide and modulo wait on the one-bit-a-cycle restoring divider over a 48-bit
// dividend; each stack read uses the registered read of the stack memory.
// Reset clears the stack pointer, variable marks, recent value and skip flag.
// A finished result waits in the output register while the next command is
// taken; the controller stalls before loading it only if that register is full.
module rpn_stack_calculator_top #(
    parameter int STACK_DEPTH    = 128,
    parameter int VARIABLE_COUNT = 26
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // [31:0] number_value, [36:32] variable_index
    input  logic [3:0]  i_s_axis_tuser,  // [3:0] action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // [31:0] shown_value, [34:32] status
    output logic        o_m_axis_tuser   // [0] value_shown
);
    import rpn_pkg::*;

    t_dp_cmd         cmd;
    t_dp_stat        stat;
    logic [ValW-1:0] shown_value;
    logic [2:0]      status;

    rpn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rpn_dp #(
        .STACK_DEPTH    (STACK_DEPTH),
        .VARIABLE_COUNT (VARIABLE_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_action         (i_s_axis_tuser),
        .i_number_value   (i_s_axis_tdata[31:0]),
        .i_variable_index (i_s_axis_tdata[36:32]),
        .i_out_ready      (i_m_axis_tready),
        .o_out_valid      (o_m_axis_tvalid),
        .o_shown_value    (shown_value),
        .o_value_shown    (o_m_axis_tuser),
        .o_status         (status)
    );

    // Pack the result transfer
    assign o_m_axis_tdata = {5'd0, status, shown_value};

endmodule

[hw/rtl/rpn_chk.sv]
// Port-level checker for the RPN stack calculator, bound to the top level.
module rpn_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [39:0] i_s_axis_tdata,
    input logic [3:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);
    // Hold a stalled result transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result changed while stalled");

    // No printed value means a zero value field
    a_zero_unshown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata[31:0] == 32'd0))
        else $error("value present without print");

    // Status code stays within the defined codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[34:32] <= 3'd5))
        else $error("status code out of range");

    // Drop ready for the command being worked on
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("ready while a command is in progress");

    // Come out of reset with no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");
endmodule

bind rpn_stack_calculator_top rpn_chk u_rpn_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
